@@ rtl/rpool_pkg.sv @@
// Shared request codes, status codes and field widths of the slot pool.
package rpool_pkg;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 6;
    localparam int SEQ_W    = 64;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 80;   // 73 bits of fields, padded to whole bytes
    localparam int M_DATA_W = 16;   // 9 bits of fields, padded to whole bytes

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_QUERY   = 3'd0;
    localparam req_t REQ_ACQUIRE = 3'd1;
    localparam req_t REQ_RELEASE = 3'd2;
    localparam req_t REQ_PREPARE = 3'd3;
    localparam req_t REQ_SUBMIT  = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_COUNT_ERR = 2'd2;

endpackage

@@ rtl/refcounted_slot_pool.sv @@
// Slot pool top level: reference counts in RAM, hint and zero-count vectors in flops.
//
// Reference-counted slot pool for a one-writer, many-reader latest-value channel.
// For every request, in the accept cycle the slot is chosen (the
// latest slot, the given slot, or the lowest free slot from a priority encoder
// over the hint and zero-count bits) and its count is read from the count RAM;
// in the next cycle the count is modified and written back and the result item
// is loaded into the output register. A new item waits until the last one has
// executed and the output side keeps up. The count RAM needs no clearing pass after
// reset: a per-slot written bit makes an unwritten slot read as its reset count.
module refcounted_slot_pool
    import rpool_pkg::*;
#(
    parameter int SLOT_COUNT  = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // req_type [2:0], slot_index [8:3], sequence_req [72:9], zero pad [79:73]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // granted_slot [5:0], has_new [6], status [8:7], zero pad [15:9]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W+1)'(SLOT_COUNT);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                   state_reg;
    logic                   accept;

    req_t                   s_req;
    logic [IDX_W-1:0]       s_idx;
    logic [SEQ_W-1:0]       s_seq;

    req_t                   req_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic                   idx_ok_reg;
    logic                   found_reg;
    logic [SLOT_W-1:0]      addr_reg;
    logic [SLOT_W-1:0]      addr_next;

    logic [SLOT_COUNT-1:0]  hint_reg;
    logic [SLOT_COUNT-1:0]  hint_next;
    logic [SLOT_COUNT-1:0]  zero_reg;
    logic [SLOT_COUNT-1:0]  written_reg;
    logic [SLOT_W-1:0]      latest_reg;
    logic [SEQ_W-1:0]       latest_seq_reg;

    logic [SLOT_COUNT-1:0]  free_vec;
    logic                   free_any;
    logic [SLOT_W-1:0]      free_idx;

    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   wr_en;

    logic [SLOT_W-1:0]      granted;
    logic                   has_new;
    status_t                status;

    logic                   m_tvalid_reg;
    logic [IDX_W-1:0]       m_granted_reg;
    logic                   m_has_new_reg;
    status_t                m_status_reg;

    assign s_req = s_tdata[REQ_W-1:0];
    assign s_idx = s_tdata[REQ_W+IDX_W-1:REQ_W];
    assign s_seq = s_tdata[REQ_W+IDX_W+SEQ_W-1:REQ_W+IDX_W];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Lowest slot with a clear hint and a zero count.
    assign free_vec = ~hint_reg & zero_reg;
    assign free_any = |free_vec;
    always_comb begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        case (s_req)
            REQ_RELEASE: addr_next = s_idx[SLOT_W-1:0];
            REQ_PREPARE: addr_next = free_idx;
            default:     addr_next = latest_reg;
        endcase
    end

    rpool_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (wr_en && (state_reg == ST_EXEC)),
        .wr_addr (addr_reg),
        .wr_data (cnt_next),
        .rd_en   (accept),
        .rd_addr (addr_next),
        .rd_data (rd_data)
    );

    // Unwritten slots read as their reset count: one for slot 0, zero elsewhere.
    assign cnt_cur = written_reg[addr_reg] ? rd_data
                   : {{(COUNT_WIDTH-1){1'b0}}, addr_reg == '0};

    always_comb begin
        wr_en     = 1'b0;
        cnt_next  = cnt_cur;
        hint_next = hint_reg;
        granted   = '0;
        has_new   = 1'b0;
        status    = ST_OK;
        case (req_reg)
            REQ_QUERY: begin
                has_new = latest_seq_reg > seq_reg;
            end
            REQ_ACQUIRE: begin
                granted             = addr_reg;
                hint_next[addr_reg] = 1'b1;
                if (cnt_cur == COUNT_MAX) begin
                    status = ST_COUNT_ERR;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_cur + COUNT_ONE;
                end
            end
            REQ_PREPARE: begin
                if (found_reg) begin
                    wr_en    = 1'b1;
                    cnt_next = COUNT_ONE;
                    granted  = addr_reg;
                end else begin
                    status = ST_FULL;
                end
            end
            REQ_RELEASE, REQ_SUBMIT: begin
                // drop one reference; release uses the given slot, submit the old latest
                if (idx_ok_reg) begin
                    if (cnt_cur == '0) begin
                        status              = ST_COUNT_ERR;
                        hint_next[addr_reg] = 1'b0;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_cur - COUNT_ONE;
                        if (cnt_cur == COUNT_ONE) begin
                            hint_next[addr_reg] = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hint_reg       <= '0;
            zero_reg       <= {{(SLOT_COUNT-1){1'b1}}, 1'b0};
            written_reg    <= '0;
            latest_reg     <= '0;
            latest_seq_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_EXEC) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg    <= ST_IDLE;
                    hint_reg     <= hint_next;
                    m_tvalid_reg <= 1'b1;
                    if (wr_en) begin
                        zero_reg[addr_reg]    <= cnt_next == '0;
                        written_reg[addr_reg] <= 1'b1;
                    end
                    if (req_reg == REQ_SUBMIT && idx_ok_reg) begin
                        latest_reg     <= idx_reg[SLOT_W-1:0];
                        latest_seq_reg <= seq_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Request and result payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_req;
            idx_reg    <= s_idx;
            seq_reg    <= s_seq;
            idx_ok_reg <= {1'b0, s_idx} < SLOT_LIMIT;
            found_reg  <= free_any;
            addr_reg   <= addr_next;
        end
        if (state_reg == ST_EXEC) begin
            m_granted_reg <= IDX_W'(granted);
            m_has_new_reg <= has_new;
            m_status_reg  <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W-1-STATUS_W){1'b0}},
                       m_status_reg, m_has_new_reg, m_granted_reg};

    // The zero-count vector must agree with the count read from memory.
    a_zero_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> ((cnt_cur == '0) == zero_reg[addr_reg]))
        else $error("zero-count bit disagrees with stored count");

    // A prepare never grants a slot that readers still hint at.
    a_prepare_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && req_reg == REQ_PREPARE && found_reg)
        |-> (!hint_reg[addr_reg] && cnt_cur == '0))
        else $error("prepare granted a busy slot");

    // A result appears only after an accepted item has executed.
    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(accept, 2) || $past(state_reg == ST_EXEC))
        else $error("result without a request");

    // Nothing is accepted while a request is in flight.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC && !s_tready))
        else $error("second item accepted during execution");

    a_latest_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, IDX_W'(latest_reg)} < SLOT_LIMIT)
        else $error("latest slot out of range");

endmodule

@@ rtl/rpool_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rpool_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
